FILE: design/bm25ts_pkg.sv
// ----------------------------------------------------------------------------
// bm25ts_pkg
// Shared types, register indexes, widths and the divider step for the
// BM25+ term score pipeline.
// ----------------------------------------------------------------------------
package bm25ts_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_K1_PLUS_ONE    = 3'd0,
      CSR_K1_ONE_MINUS_B = 3'd1,
      CSR_LEN_SCALE      = 3'd2,   // k1*b, scales the length term
      CSR_DELTA_BONUS    = 3'd3,
      CSR_IDF_WEIGHT     = 3'd4,
      CSR_INV_AVG_LEN    = 3'd5
   } csr_index_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   // reset values
   localparam logic [15:0] K1PlusOneReset   = 16'd8995;
   localparam logic [15:0] K1OneMinusBReset = 16'd1229;
   localparam logic [15:0] LenScaleReset    = 16'd3686;
   localparam logic [15:0] DeltaBonusReset  = 16'd0;
   localparam logic [15:0] IdfWeightReset   = 16'd1024;
   localparam logic [23:0] InvAvgLenReset   = 24'hFFFFFF;

   // divider: 20 quotient bits, two per stage
   localparam int DivSteps      = 20;
   localparam int StepsPerStage = 2;
   localparam int DivStages     = DivSteps / StepsPerStage;
   localparam int DivLast       = DivStages - 1;

   // stages from input register to output register
   localparam int PipeDepth = DivStages + 5;

   // Q.26 to Q.16 rounding and the signed 32-bit score range
   localparam logic signed [37:0] RoundBias = 38'sd512;
   localparam logic signed [37:0] ScoreMax  = 38'sd2147483647;
   localparam logic signed [37:0] ScoreMin  = -38'sd2147483648;

   typedef struct packed {
      logic [32:0] rem;   // partial remainder, below den unless den is zero
      logic [32:0] den;   // Q.12 denominator
      logic [19:0] feed;  // dividend bits still to shift in, msb first
      logic [19:0] quo;   // quotient bits so far
      logic        zden;  // denominator was zero
      logic        last;
   } div_stage_type;

   // one restoring division step: shift in a dividend bit, try subtract
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [33:0]   t;
      logic [33:0]   d;
      logic          qb;
      r  = s;
      t  = {s.rem, s.feed[19]};
      d  = {1'b0, s.den};
      qb = (t >= d);
      if (qb) begin
         t = t - d;
      end
      r.rem  = t[32:0];
      r.feed = {s.feed[18:0], 1'b0};
      r.quo  = {s.quo[18:0], qb};
      return r;
   endfunction

endpackage

FILE: design/bm25ts_div.sv
// ----------------------------------------------------------------------------
// bm25ts_div
// Pipelined restoring divider, two quotient bits per stage, with a per-stage
// valid bit and a ready chain so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module bm25ts_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  bm25ts_pkg::div_stage_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output bm25ts_pkg::div_stage_type out_data
);

   bm25ts_pkg::div_stage_type stage_ff [bm25ts_pkg::DivStages];
   bm25ts_pkg::div_stage_type stage_in [bm25ts_pkg::DivStages];
   logic [bm25ts_pkg::DivStages-1:0] v_ff;
   logic [bm25ts_pkg::DivStages-1:0] ld;
   logic [bm25ts_pkg::DivStages-1:0] src_v;

   for (genvar k = 0; k < bm25ts_pkg::DivStages; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_v[k] = in_valid;
         always_comb begin
            stage_in[k] = in_data;
            for (int j = 0; j < bm25ts_pkg::StepsPerStage; j++) begin
               stage_in[k] = bm25ts_pkg::div_step(stage_in[k]);
            end
         end
      end else begin : g_rest
         assign src_v[k] = v_ff[k-1];
         always_comb begin
            stage_in[k] = stage_ff[k-1];
            for (int j = 0; j < bm25ts_pkg::StepsPerStage; j++) begin
               stage_in[k] = bm25ts_pkg::div_step(stage_in[k]);
            end
         end
      end

      if (k == bm25ts_pkg::DivLast) begin : g_ld_last
         assign ld[k] = !v_ff[k] || out_ready;
      end else begin : g_ld_mid
         assign ld[k] = !v_ff[k] || ld[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (ld[k]) begin
            v_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ld[k] && src_v[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[bm25ts_pkg::DivLast];
   assign out_data  = stage_ff[bm25ts_pkg::DivLast];

endmodule

FILE: design/bm25_term_score.sv
// ----------------------------------------------------------------------------
// bm25_term_score
// BM25+ term contribution per posting: idf * (tf*(k1+1)/D + delta), with
// D = tf + k1(1-b) + k1*b*dl/avgdl, all fixed point, score signed Q15.16.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: term_freq, doc_len; tlast: last_in
// rsp      out  rsp_tvalid/tready    tdata: score, zero_den, saturated;
//                                    tlast: last_out
// csr      in   csr_valid/csr_ready  csr_index, csr_wdata (always ready)
//
// One posting per cycle while rsp_tready holds; the pipeline is the 10-stage
// divider (two quotient bits per stage) plus five arithmetic stages.
// Reset is synchronous: all valid bits clear, configuration registers take defaults.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so a stalled rsp side fills bubbles before req_tready drops.
// Configuration is read live by the stages; write it only when idle.
//
module bm25_term_score (
   input  logic        clock,
   input  logic        reset,
   // input postings
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] term_freq, [31:16] doc_len
   input  logic        req_tlast,   // last_in
   // scores
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] score, [32] zero_denominator,
                                    // [33] saturated, [39:34] zero
   output logic        rsp_tlast,   // last_out
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bm25ts_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bm25ts_pkg::CsrDataWidth-1:0]  csr_wdata
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] k1p1_ff, k1omb_ff, k1b_ff, delta_ff, idf_ff;
   logic [23:0] inv_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1p1_ff  <= bm25ts_pkg::K1PlusOneReset;
         k1omb_ff <= bm25ts_pkg::K1OneMinusBReset;
         k1b_ff   <= bm25ts_pkg::LenScaleReset;
         delta_ff <= bm25ts_pkg::DeltaBonusReset;
         idf_ff   <= bm25ts_pkg::IdfWeightReset;
         inv_ff   <= bm25ts_pkg::InvAvgLenReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bm25ts_pkg::CSR_K1_PLUS_ONE:    k1p1_ff  <= csr_wdata[15:0];
            bm25ts_pkg::CSR_K1_ONE_MINUS_B: k1omb_ff <= csr_wdata[15:0];
            bm25ts_pkg::CSR_LEN_SCALE:      k1b_ff   <= csr_wdata[15:0];
            bm25ts_pkg::CSR_DELTA_BONUS:    delta_ff <= csr_wdata[15:0];
            bm25ts_pkg::CSR_IDF_WEIGHT:     idf_ff   <= csr_wdata[15:0];
            bm25ts_pkg::CSR_INV_AVG_LEN:    inv_ff   <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage control: each stage loads when empty or when drained downstream
   // ---------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   logic ld1, ld2, ld3, ld4, ld5;
   logic div_in_ready, div_out_valid;
   bm25ts_pkg::div_stage_type div_out;

   assign ld5 = !rsp_v_ff || rsp_tready;
   assign ld4 = !s4_v_ff || ld5;
   assign ld3 = !s3_v_ff || div_in_ready;
   assign ld2 = !s2_v_ff || ld3;
   assign ld1 = !s1_v_ff || ld2;

   assign req_tready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (ld1) s1_v_ff  <= req_tvalid;
         if (ld2) s2_v_ff  <= s1_v_ff;
         if (ld3) s3_v_ff  <= s2_v_ff;
         if (ld4) s4_v_ff  <= div_out_valid;
         if (ld5) rsp_v_ff <= s4_v_ff;
      end
   end

   // ---------------------------------------------------------------------
   // S1: k1*b*dl and numerator tf*(k1+1), both 16x16
   // ---------------------------------------------------------------------
   logic [31:0] s1_lenprod_ff, s1_numer_ff;
   logic [15:0] s1_tf_ff;
   logic        s1_last_ff;

   always_ff @(posedge clock) begin
      if (ld1 && req_tvalid) begin
         s1_lenprod_ff <= 32'(k1b_ff) * 32'(req_tdata[31:16]);
         s1_numer_ff   <= 32'(req_tdata[15:0]) * 32'(k1p1_ff);
         s1_tf_ff      <= req_tdata[15:0];
         s1_last_ff    <= req_tlast;
      end
   end

   // ---------------------------------------------------------------------
   // S2: length term, Q.36, 32x24
   // ---------------------------------------------------------------------
   logic [55:0] s2_len_ff;
   logic [31:0] s2_numer_ff;
   logic [15:0] s2_tf_ff;
   logic        s2_last_ff;

   always_ff @(posedge clock) begin
      if (ld2 && s1_v_ff) begin
         s2_len_ff   <= 56'(s1_lenprod_ff) * 56'(inv_ff);
         s2_numer_ff <= s1_numer_ff;
         s2_tf_ff    <= s1_tf_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // S3: Q.12 denominator and divider setup. tf and k1(1-b) have no bits
   // below 2^24 in Q.36, so only the length term is truncated.
   // Dividend is numer << 16; the quotient fits 20 bits, so the top 28
   // bits start as the remainder and the low 20 are shifted in.
   // ---------------------------------------------------------------------
   logic [32:0]               s3_den;
   bm25ts_pkg::div_stage_type s3_in, s3_ff;

   always_comb begin
      s3_den     = {5'd0, s2_tf_ff, 12'd0} + {17'd0, k1omb_ff} + {1'b0, s2_len_ff[55:24]};
      s3_in.rem  = {5'd0, s2_numer_ff[31:4]};
      s3_in.den  = s3_den;
      s3_in.feed = {s2_numer_ff[3:0], 16'd0};
      s3_in.quo  = '0;
      s3_in.zden = (s3_den == '0);
      s3_in.last = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (ld3 && s2_v_ff) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------------
   // divider: normalized tf, Q.16
   // ---------------------------------------------------------------------
   bm25ts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (div_in_ready),
      .in_data   (s3_ff),
      .out_valid (div_out_valid),
      .out_ready (ld4),
      .out_data  (div_out)
   );

   // ---------------------------------------------------------------------
   // S4: add delta, multiply by idf (Q.26). A zero denominator forces the
   // quotient to zero (the divider returns all ones there).
   // ---------------------------------------------------------------------
   logic [19:0]        s4_tn;
   logic [20:0]        s4_sum;
   logic signed [37:0] s4_prod_ff;
   logic               s4_zden_ff, s4_last_ff;

   assign s4_tn  = div_out.zden ? '0 : div_out.quo;
   assign s4_sum = {1'b0, s4_tn} + {1'b0, delta_ff, 4'd0};

   always_ff @(posedge clock) begin
      if (ld4 && div_out_valid) begin
         s4_prod_ff <= 38'($signed(idf_ff)) * 38'($signed({1'b0, s4_sum}));
         s4_zden_ff <= div_out.zden;
         s4_last_ff <= div_out.last;
      end
   end

   // ---------------------------------------------------------------------
   // S5: round to Q.16 (half up), clamp, output register
   // ---------------------------------------------------------------------
   logic signed [37:0] s5_round;
   logic               s5_hi, s5_lo;
   logic [31:0]        s5_score;
   logic [31:0]        rsp_score_ff;
   logic               rsp_zden_ff, rsp_sat_ff, rsp_last_ff;

   always_comb begin
      s5_round = (s4_prod_ff + bm25ts_pkg::RoundBias) >>> 10;
      s5_hi    = (s5_round > bm25ts_pkg::ScoreMax);
      s5_lo    = (s5_round < bm25ts_pkg::ScoreMin);
      if (s5_hi) begin
         s5_score = bm25ts_pkg::ScoreMax[31:0];
      end else if (s5_lo) begin
         s5_score = bm25ts_pkg::ScoreMin[31:0];
      end else begin
         s5_score = s5_round[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld5 && s4_v_ff) begin
         rsp_score_ff <= s5_score;
         rsp_zden_ff  <= s4_zden_ff;
         rsp_sat_ff   <= s5_hi || s5_lo;
         rsp_last_ff  <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'd0, rsp_sat_ff, rsp_zden_ff, rsp_score_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/bm25ts_chk.sv
// ----------------------------------------------------------------------------
// bm25ts_chk
// Port-level checks for bm25_term_score, bound to the top level.
// ----------------------------------------------------------------------------
module bm25ts_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // transactions in flight
   logic [4:0] cnt_ff, cnt_in;
   logic       in_acc, out_acc;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (in_acc && !out_acc) begin
         cnt_in = cnt_ff + 5'd1;
      end else if (out_acc && !in_acc) begin
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // every result has an accepted posting behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 5'd0)
      else $error("rsp transaction without a pending posting");

   // never more postings in flight than pipeline stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'(bm25ts_pkg::PipeDepth))
      else $error("more transactions in flight than stages");

   // score range cannot reach the clamp; padding stays zero
   a_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[33] && rsp_tdata[39:34] == 6'd0)
      else $error("saturated flag or padding set");

endmodule

bind bm25_term_score bm25ts_chk u_bm25ts_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bm25_term_score. A clocked driver feeds postings
// from a queue, a clocked monitor checks every score against a fixed-point
// predictor that tracks the register file. The run goes through several
// register settings (reset values, all-ones but idf 7FFF, all-zeros but
// idf 8000, random), written over csr only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          RandomPerPhase = 215;
   localparam int          PhaseCount     = 9;
   localparam int          SteadyPhase    = 5;     // no idling on either side
   localparam int          DrainCycles    = 40;    // more than bm25ts_pkg::PipeDepth
   localparam int          CycleLimit     = 400000;
   localparam int          MaxReports     = 10;
   // indexes past the register file, writes to them must be dropped
   localparam logic [2:0]  CsrUnusedLo    = 3'd6;
   localparam logic [2:0]  CsrUnusedHi    = 3'd7;
   localparam longint      ScoreMax       = (longint'(1) << 31) - 1;
   localparam longint      ScoreMin       = -(longint'(1) << 31);

   typedef struct packed {
      logic [15:0] k1_plus_one;
      logic [15:0] k1_one_minus_b;
      logic [15:0] len_scale;       // k1*b
      logic [15:0] delta_bonus;
      logic [15:0] idf_weight;      // signed Q5.10
      logic [23:0] inv_avg_len;
   } term_params_type;

   typedef struct packed {
      logic [15:0] term_freq;
      logic [15:0] doc_len;
      logic        last_in;
   } posting_type;

   typedef struct packed {
      logic [31:0] score;
      logic        zero_den;
      logic        saturated;
      logic        last_out;
   } term_score_type;

   typedef struct packed {
      logic [15:0]    term_freq;
      logic [15:0]    doc_len;
      term_score_type result;
   } pending_score_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;      // [15:0] term_freq, [31:16] doc_len
   logic        req_tlast  = 1'b0;    // last_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [31:0] score, [32] zero_den, [33] saturated
   logic        rsp_tlast;            // last_out
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [bm25ts_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [bm25ts_pkg::CsrDataWidth-1:0]  csr_wdata = '0;

   term_params_type   params;            // mirror of the block's register file
   posting_type       posting_queue[$];  // postings not yet presented
   pending_score_type score_queue[$];    // scores owed by the block, oldest first
   logic              steady     = 1'b0;
   int                mismatches = 0;
   int                cycle_count = 0;

   bm25_term_score uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // BM25+ contribution in exact integer arithmetic:
   // D = floor(((tf<<36) + (k1(1-b)<<24) + k1b*dl*inv) >> 24)   Q.12
   // tn = floor((tf*(k1+1) << 16) / D), or 0 with the flag when D is zero
   // score = round_half_up(idf * (tn + delta<<4) / 1024), clamped to 32 bits
   function automatic term_score_type predict_score(input term_params_type prm,
                                                    input logic [15:0] tf_in,
                                                    input logic [15:0] dl_in,
                                                    input logic last_in);
      longint unsigned tf;
      longint unsigned dl;
      longint unsigned len_term;
      longint unsigned denom36;
      longint unsigned denom12;
      longint unsigned numer;
      longint unsigned tnorm;
      longint unsigned sum_q16;
      longint          prod;
      longint          rounded;
      term_score_type  res;
      tf       = 64'(tf_in);
      dl       = 64'(dl_in);
      len_term = 64'(prm.len_scale) * dl * 64'(prm.inv_avg_len);
      denom36  = (tf << 36) + (64'(prm.k1_one_minus_b) << 24) + len_term;
      denom12  = denom36 >> 24;
      numer    = tf * 64'(prm.k1_plus_one);
      res.zero_den = (denom12 == 0);
      tnorm    = res.zero_den ? 64'd0 : (numer << 16) / denom12;
      sum_q16  = tnorm + (64'(prm.delta_bonus) << 4);
      prod     = longint'($signed(prm.idf_weight)) * longint'(sum_q16);
      rounded  = (prod + 512) >>> 10;
      res.saturated = 1'b0;
      if (rounded > ScoreMax) begin
         rounded = ScoreMax;
         res.saturated = 1'b1;
      end else if (rounded < ScoreMin) begin
         rounded = ScoreMin;
         res.saturated = 1'b1;
      end
      res.score    = rounded[31:0];
      res.last_out = last_in;
      return res;
   endfunction

   // register file update, out-of-range indexes and high bits are dropped
   task automatic apply_csr(input logic [2:0] idx, input logic [23:0] data);
      case (idx)
         bm25ts_pkg::CSR_K1_PLUS_ONE:    params.k1_plus_one    = data[15:0];
         bm25ts_pkg::CSR_K1_ONE_MINUS_B: params.k1_one_minus_b = data[15:0];
         bm25ts_pkg::CSR_LEN_SCALE:      params.len_scale      = data[15:0];
         bm25ts_pkg::CSR_DELTA_BONUS:    params.delta_bonus    = data[15:0];
         bm25ts_pkg::CSR_IDF_WEIGHT:     params.idf_weight     = data[15:0];
         bm25ts_pkg::CSR_INV_AVG_LEN:    params.inv_avg_len    = data;
         default: ;
      endcase
   endtask

   // called at a rising edge; leaves csr_valid high for a following write
   task automatic csr_write(input logic [2:0] idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   // 16-bit registers get junk in the unused high byte
   task automatic write_params(input term_params_type prm);
      @(posedge clock);
      csr_write(bm25ts_pkg::CSR_K1_PLUS_ONE,    {8'($urandom), prm.k1_plus_one});
      csr_write(bm25ts_pkg::CSR_K1_ONE_MINUS_B, {8'($urandom), prm.k1_one_minus_b});
      csr_write(bm25ts_pkg::CSR_LEN_SCALE,      {8'($urandom), prm.len_scale});
      csr_write(bm25ts_pkg::CSR_DELTA_BONUS,    {8'($urandom), prm.delta_bonus});
      csr_write(bm25ts_pkg::CSR_IDF_WEIGHT,     {8'($urandom), prm.idf_weight});
      csr_write(bm25ts_pkg::CSR_INV_AVG_LEN,    prm.inv_avg_len);
      csr_write(CsrUnusedLo,                    24'($urandom));
      csr_write(CsrUnusedHi,                    24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // realistic settings most of the time: k1 in [1,2], b in [0,1] with b = 1
   // often (zero k1(1-b) lets tf = 0 reach a zero denominator)
   function automatic term_params_type phase_params(input int phase);
      term_params_type prm;
      int              k1;
      int              b;
      case (phase)
         1: prm = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 24'hFFFFFF};
         2: prm = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 24'h000000};
         default: begin
            if ($urandom_range(2) == 0) begin
               prm = term_params_type'(104'({$urandom, $urandom, $urandom, $urandom}));
            end else begin
               k1 = $urandom_range(8192, 4096);
               b  = ($urandom_range(3) == 0) ? 4096 : $urandom_range(4096, 0);
               prm.k1_plus_one    = 16'(k1 + 4096);
               prm.k1_one_minus_b = 16'((k1 * (4096 - b)) >> 12);
               prm.len_scale      = 16'((k1 * b) >> 12);
               prm.delta_bonus    = 16'($urandom_range(4096, 0));
               prm.idf_weight     = 16'(int'($urandom_range(14336, 0)) - 2048);
               prm.inv_avg_len    = 24'((1 << 24) / $urandom_range(2000, 1));
            end
         end
      endcase
      return prm;
   endfunction

   task automatic push_posting(input logic [15:0] tf, input logic [15:0] dl,
                               input logic last);
      posting_queue.push_back('{tf, dl, last});
   endtask

   // mostly small tf and plausible lengths, with zeros and full-range noise
   task automatic push_random_posting();
      logic [15:0] tf;
      logic [15:0] dl;
      int          pick;
      pick = $urandom_range(9);
      tf   = 16'($urandom_range(30, 1));
      dl   = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(3000, 0));
      if (pick == 0) begin
         tf = 16'($urandom);
         dl = 16'($urandom);
      end else if (pick == 1) begin
         tf = 16'd0;
      end
      push_posting(tf, dl, $urandom_range(7) == 0);
   endtask

   task automatic wait_idle();
      while (posting_queue.size() != 0 || req_tvalid || score_queue.size() != 0)
         @(negedge clock);
   endtask

   // driver: predict on acceptance, then present the next posting or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            score_queue.push_back('{req_tdata[15:0], req_tdata[31:16],
                                    predict_score(params, req_tdata[15:0],
                                                  req_tdata[31:16], req_tlast)});
         end
         if (!req_tvalid || req_tready) begin
            if (posting_queue.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {posting_queue[0].doc_len, posting_queue[0].term_freq};
               req_tlast  <= posting_queue[0].last_in;
               posting_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare each score transaction in order
   always @(posedge clock) begin
      term_score_type    got;
      pending_score_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 33);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33], rsp_tlast};
            if (score_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("unexpected score transaction: score=%h zden=%b sat=%b last=%b",
                           got.score, got.zero_den, got.saturated, got.last_out);
            end else begin
               want = score_queue.pop_front();
               if (got !== want.result) begin
                  mismatches++;
                  if (mismatches <= MaxReports)
                     $display({"score mismatch tf=%0d dl=%0d: score exp %h got %h, ",
                               "zden exp %b got %b, sat exp %b got %b, last exp %b got %b"},
                              want.term_freq, want.doc_len,
                              want.result.score, got.score,
                              want.result.zero_den, got.zero_den,
                              want.result.saturated, got.saturated,
                              want.result.last_out, got.last_out);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** bm25_term_score: FAILED **");
         $finish;
      end
   end

   initial begin
      params = '{bm25ts_pkg::K1PlusOneReset, bm25ts_pkg::K1OneMinusBReset,
                 bm25ts_pkg::LenScaleReset, bm25ts_pkg::DeltaBonusReset,
                 bm25ts_pkg::IdfWeightReset, bm25ts_pkg::InvAvgLenReset};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         // the sender holds off here until every score of the last phase is back
         if (phase > 0) begin
            wait_idle();
            write_params(phase_params(phase));
         end
         @(negedge clock);
         steady = (phase == SteadyPhase);
         case (phase)
            0: begin
               // field extremes and alternating bit patterns at reset values
               push_posting(16'd0,     16'd0,     1'b0);
               push_posting(16'd0,     16'hFFFF,  1'b1);
               push_posting(16'hFFFF,  16'd0,     1'b0);
               push_posting(16'hFFFF,  16'hFFFF,  1'b1);
               push_posting(16'd1,     16'd0,     1'b0);
               push_posting(16'd1,     16'd1,     1'b0);
               push_posting(16'd1,     16'hFFFF,  1'b0);
               push_posting(16'hFFFF,  16'd1,     1'b1);
               push_posting(16'h5555,  16'hAAAA,  1'b0);
               push_posting(16'hAAAA,  16'h5555,  1'b1);
               push_posting(16'd3,     16'd500,   1'b0);
               push_posting(16'd10,    16'd300,   1'b1);
            end
            1: begin
               // largest constants, most positive idf
               push_posting(16'hFFFF,  16'hFFFF,  1'b0);
               push_posting(16'd0,     16'd0,     1'b1);
               push_posting(16'hFFFF,  16'd0,     1'b0);
               push_posting(16'd1,     16'hFFFF,  1'b1);
            end
            2: begin
               // zero constants but most negative idf: tf = 0 gives a zero denominator
               push_posting(16'd0,     16'd0,     1'b0);
               push_posting(16'd0,     16'hFFFF,  1'b1);
               push_posting(16'hFFFF,  16'hFFFF,  1'b0);
               push_posting(16'd1,     16'd0,     1'b1);
            end
            default: ;
         endcase
         for (int n = 0; n < RandomPerPhase; n++)
            push_random_posting();
      end

      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && score_queue.size() == 0) begin
         $display("** bm25_term_score: PASSED **");
      end else begin
         $display("** bm25_term_score: FAILED **");
      end
      $finish;
   end

endmodule
